[rtl/adfs_pkg.sv]
// Shared types, constants and the microcode table for the depth-first walk core.
// Used by adfs_seq, adfs_dpath and adjacency_matrix_dfs_order_core; no dependencies.
package adfs_pkg;

	localparam int VERTICES  = 8;
	localparam int VTX_W     = 3;
	localparam int DEPTH_W   = 4;
	localparam int ADJ_W     = 64;
	localparam int PADDR_W   = 4;

	localparam logic [VTX_W-1:0]   SCAN_LAST = VTX_W'(VERTICES - 1);
	localparam logic [DEPTH_W-1:0] STACK_MAX = DEPTH_W'(VERTICES);

	// register index sits at byte address 8*i
	localparam logic REG_ADJ = 1'b0;

	typedef logic [1:0] step_t;
	localparam step_t STEP_IDLE = 2'd0;
	localparam step_t STEP_POP  = 2'd1;
	localparam step_t STEP_SCAN = 2'd2;
	localparam step_t STEP_EMIT = 2'd3;

	typedef enum logic [1:0] {
		COND_IN     = 2'd0,
		COND_ALWAYS = 2'd1,
		COND_SCAN   = 2'd2,
		COND_EMIT   = 2'd3
	} cond_t;

	typedef struct packed {
		logic  take_in;
		logic  pop;
		logic  scan;
		logic  emit;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic in_go;
		logic scan_done;
		logic out_free;
		logic walk_last;
		logic stack_empty;
	} dp_status_t;

	function automatic ctrl_t ucode_rom(input step_t s);
		ctrl_t c;
		c = '0;
		unique case (s)
			STEP_IDLE: begin
				c.take_in = 1'b1;
				c.cond    = COND_IN;
				c.target  = STEP_POP;
			end
			STEP_POP: begin
				c.pop    = 1'b1;
				c.cond   = COND_ALWAYS;
				c.target = STEP_SCAN;
			end
			STEP_SCAN: begin
				c.scan   = 1'b1;
				c.cond   = COND_SCAN;
				c.target = STEP_EMIT;
			end
			STEP_EMIT: begin
				c.emit   = 1'b1;
				c.cond   = COND_EMIT;
				c.target = STEP_POP;
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

[rtl/adjacency_matrix_dfs_order_core.sv]
// Depth-first visit order over an 8-vertex graph held in a 64-bit adjacency register.
// A start vertex beat on the input channel yields one output beat per reachable vertex,
// in visit order, with last set on the final one. Neighbours are scanned in ascending order and visited highest first.
// Each walk runs the microcode loop once per visited vertex: one pop step, one scan step per
// column and one emit step.
// The next start vertex is taken once the last beat of the walk is in the output register.
// Adjacency matrix at APB byte address 0: bit row*8+col marks an edge from row to col.
// Depends on adfs_pkg, adfs_seq and adfs_dpath.
module adjacency_matrix_dfs_order_core import adfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [ADJ_W-1:0]   pwdata,
	output logic [ADJ_W-1:0]   prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VTX_W-1:0]   start_vertex,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VTX_W-1:0]   visited_vertex,
	output logic               last
);

	logic [ADJ_W-1:0] adj_q;
	ctrl_t            ctrl;
	step_t            step;
	dp_status_t       status;

	assign pready   = 1'b1;
	assign prdata   = (paddr[3] == REG_ADJ) ? adj_q : '0;
	assign in_ready = ctrl.take_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			adj_q <= '0;
		else if (psel && penable && pwrite && pready && paddr[3] == REG_ADJ)
			adj_q <= pwdata;
	end

	adfs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.step   (step)
	);

	adfs_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.adj_bits       (adj_q),
		.in_valid       (in_valid),
		.start_vertex   (start_vertex),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.visited_vertex (visited_vertex),
		.last           (last),
		.status         (status)
	);

	// a pop never sees an empty stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> !status.stack_empty)
		else $error("pop from empty stack");

	a_start_to_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (step == STEP_POP || step == STEP_IDLE))
		else $error("accepted start did not enter the walk");

	// after the final beat of a walk is loaded, the core is idle again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && status.out_free && status.walk_last) |=> (in_ready && last && out_valid))
		else $error("core not idle after last beat");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.scan && status.scan_done) |=> ctrl.emit)
		else $error("scan did not hand over to emit");

endmodule

[rtl/adfs_seq.sv]
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on adfs_pkg for the control word, status struct and table.
module adfs_seq import adfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t status,
	output ctrl_t      ctrl,
	output step_t      step
);

	step_t step_q;
	step_t step_nxt;

	assign ctrl = ucode_rom(step_q);
	assign step = step_q;

	always_comb begin
		step_nxt = step_q;
		unique case (ctrl.cond)
			COND_IN:     if (status.in_go) step_nxt = ctrl.target;
			COND_ALWAYS: step_nxt = ctrl.target;
			COND_SCAN:   if (status.scan_done) step_nxt = ctrl.target;
			COND_EMIT: begin
				if (status.out_free)
					step_nxt = status.walk_last ? STEP_IDLE : ctrl.target;
			end
			default:     step_nxt = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_IDLE;
		else
			step_q <= step_nxt;
	end

endmodule

[rtl/adfs_dpath.sv]
// Datapath: LIFO stack, visited/pending marks, neighbour scan and output register.
// Depends on adfs_pkg; driven by the control word from adfs_seq.
module adfs_dpath import adfs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_t            ctrl,
	input  logic [ADJ_W-1:0] adj_bits,
	input  logic             in_valid,
	input  logic [VTX_W-1:0] start_vertex,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [VTX_W-1:0] visited_vertex,
	output logic             last,
	output dp_status_t       status
);

	logic [VTX_W-1:0]    stack_q [VERTICES];
	logic [DEPTH_W-1:0]  depth_q;
	logic [VERTICES-1:0] visited_q;
	logic [VERTICES-1:0] pending_q;
	logic [VTX_W-1:0]    cur_v_q;
	logic [VTX_W-1:0]    scan_q;
	logic [DEPTH_W-1:0]  count_q;
	logic                out_valid_q;
	logic [VTX_W-1:0]    out_v_q;
	logic                out_last_q;

	logic               start_ok;
	logic               in_acc;
	logic [DEPTH_W-1:0] top_idx;
	logic [VTX_W-1:0]   pop_v;
	logic               edge_bit;
	logic               seen;
	logic               do_push;
	logic               wr_en;
	logic [VTX_W-1:0]   wr_addr;
	logic [VTX_W-1:0]   wr_data;
	logic               out_free;
	logic               walk_last;

	assign start_ok = {1'b0, start_vertex} < DEPTH_W'(VERTICES);
	assign in_acc   = ctrl.take_in && in_valid;
	assign top_idx  = depth_q - DEPTH_W'(1);
	assign pop_v    = stack_q[top_idx[VTX_W-1:0]];
	// row stride is fixed at eight columns
	assign edge_bit = adj_bits[{cur_v_q, scan_q}];
	assign seen     = visited_q[scan_q] | pending_q[scan_q];
	assign do_push  = ctrl.scan && edge_bit && !seen && (depth_q < STACK_MAX);

	assign wr_en   = (in_acc && start_ok) || do_push;
	assign wr_addr = in_acc ? '0 : depth_q[VTX_W-1:0];
	assign wr_data = in_acc ? start_vertex : scan_q;

	assign out_free  = !out_valid_q || out_ready;
	assign walk_last = (depth_q == '0) || (count_q == DEPTH_W'(VERTICES));

	assign status.in_go       = in_acc && start_ok;
	assign status.scan_done   = scan_q == SCAN_LAST;
	assign status.out_free    = out_free;
	assign status.walk_last   = walk_last;
	assign status.stack_empty = depth_q == '0;

	assign out_valid      = out_valid_q;
	assign visited_vertex = out_v_q;
	assign last           = out_last_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			stack_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			visited_q   <= '0;
			pending_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				visited_q <= '0;
				count_q   <= '0;
				if (start_ok) begin
					depth_q   <= DEPTH_W'(1);
					pending_q <= VERTICES'(1) << start_vertex;
				end else begin
					depth_q   <= '0;
					pending_q <= '0;
				end
			end
			if (ctrl.pop) begin
				depth_q   <= top_idx;
				pending_q <= pending_q & ~(VERTICES'(1) << pop_v);
				visited_q <= visited_q | (VERTICES'(1) << pop_v);
				count_q   <= count_q + DEPTH_W'(1);
			end
			if (do_push) begin
				depth_q   <= depth_q + DEPTH_W'(1);
				pending_q <= pending_q | (VERTICES'(1) << scan_q);
			end
			if (ctrl.emit && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			cur_v_q <= pop_v;
			scan_q  <= '0;
		end else if (ctrl.scan && scan_q != SCAN_LAST) begin
			scan_q <= scan_q + VTX_W'(1);
		end
		if (ctrl.emit && out_free) begin
			out_v_q    <= cur_v_q;
			out_last_q <= walk_last;
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for adjacency_matrix_dfs_order_core: directed and random start
// vertices over a run of adjacency settings, each walk predicted in-bench and checked beat by beat.
// Depends on adfs_pkg and the core RTL only.
module tb import adfs_pkg::*; ;

	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		logic             last;
	} visit_t;

	typedef enum int {
		GRAPH_DENSE,
		GRAPH_SPARSE,
		GRAPH_SYMMETRIC,
		GRAPH_TREE
	} graph_kind_t;

	localparam logic [PADDR_W-1:0] ADJ_ADDR = PADDR_W'(8 * REG_ADJ);
	localparam int WALK_CYCLES   = 1 + VERTICES * (VERTICES + 2);
	localparam int IDLE_LIMIT    = 2000;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 18;

	// Predicts the visit order of each walk and holds the beats still owed by the core
	class dfs_visit_board;
		logic [ADJ_W-1:0] adjacency;
		visit_t           expected_visits[$];
		int               mismatches;
		int               visits_checked;
		int               walks;

		function new();
			adjacency      = '0;
			mismatches     = 0;
			visits_checked = 0;
			walks          = 0;
		endfunction

		function void note_start(logic [VTX_W-1:0] root);
			logic [VERTICES-1:0] seen;
			logic [VERTICES-1:0] queued;
			logic [VTX_W-1:0]    lifo [VERTICES];
			logic [VTX_W-1:0]    order[$];
			logic [VTX_W-1:0]    v;
			visit_t              beat;
			int                  depth;
			seen   = '0;
			queued = '0;
			if (int'(root) >= VERTICES) begin
				return;
			end
			walks++;
			lifo[0]      = root;
			depth        = 1;
			queued[root] = 1'b1;
			while (depth > 0 && order.size() < VERTICES) begin
				depth--;
				v         = lifo[depth];
				queued[v] = 1'b0;
				seen[v]   = 1'b1;
				order.insert(order.size(), v);
				// ascending scan; visited or already stacked neighbours are skipped
				for (int col = 0; col < VERTICES; col++) begin
					if (adjacency[int'(v) * 8 + col] && !seen[col] && !queued[col]
							&& depth < VERTICES) begin
						lifo[depth] = VTX_W'(col);
						queued[col] = 1'b1;
						depth++;
					end
				end
			end
			foreach (order[k]) begin
				beat.vertex = order[k];
				beat.last   = (k == order.size() - 1);
				expected_visits.insert(expected_visits.size(), beat);
			end
		endfunction

		function void check_visit(logic [VTX_W-1:0] vertex, logic last_flag);
			visit_t want;
			if (expected_visits.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: unexpected beat vertex=%0d last=%0b", $realtime, vertex,
						last_flag);
				end
				return;
			end
			want = expected_visits.pop_front();
			visits_checked++;
			if (want.vertex !== vertex || want.last !== last_flag) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: beat mismatch: vertex exp %0d got %0d, last exp %0b got %0b",
						$realtime, want.vertex, vertex, want.last, last_flag);
				end
			end
		endfunction

		function int outstanding();
			return expected_visits.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [ADJ_W-1:0]   pwdata;
	logic [ADJ_W-1:0]   prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [VTX_W-1:0]   start_vertex;
	logic               out_valid;
	logic               out_ready;
	logic [VTX_W-1:0]   visited_vertex;
	logic               last;

	dfs_visit_board board = new();
	bit             steady;
	int             idle_cycles;
	int             cfg_errors;
	int             graphs_loaded;

	adjacency_matrix_dfs_order_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.start_vertex   (start_vertex),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.visited_vertex (visited_vertex),
		.last           (last)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one; none at all in steady phases
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ADJ_W-1:0] make_graph(graph_kind_t kind);
		logic [ADJ_W-1:0] g;
		int               parent;
		g = '0;
		case (kind)
			GRAPH_DENSE: begin
				g = {$urandom, $urandom};
			end
			GRAPH_SPARSE: begin
				g = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			end
			GRAPH_SYMMETRIC: begin
				for (int i = 0; i < VERTICES; i++) begin
					for (int j = i + 1; j < VERTICES; j++) begin
						if ($urandom_range(0, 2) == 0) begin
							g[i * 8 + j] = 1'b1;
							g[j * 8 + i] = 1'b1;
						end
					end
				end
			end
			GRAPH_TREE: begin
				// rooted at 0, some edges also pointing back up
				for (int i = 1; i < VERTICES; i++) begin
					parent = $urandom_range(0, i - 1);
					g[parent * 8 + i] = 1'b1;
					if ($urandom_range(0, 1) == 1) begin
						g[i * 8 + parent] = 1'b1;
					end
				end
			end
			default: g = '0;
		endcase
		return g;
	endfunction

	// write then read back the adjacency register
	task automatic load_adjacency(input logic [ADJ_W-1:0] g);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADJ_ADDR;
		pwdata  <= g;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.adjacency = g;
		graphs_loaded++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== g) begin
			cfg_errors++;
			$display("%0t: adjacency readback exp %h got %h", $realtime, g, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_start(input logic [VTX_W-1:0] v);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		start_vertex <= v;
		do @(posedge clk); while (!in_ready);
		board.note_start(v);
	endtask

	// stop the input, let every owed beat arrive, then let the core settle
	task automatic finish_phase(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.outstanding() > 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_visit(visited_vertex, last);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d beats still owed", $realtime,
					IDLE_LIMIT, board.outstanding());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		logic [ADJ_W-1:0] g;
		int               errors;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		start_vertex  = '0;
		steady        = 1'b0;
		cfg_errors    = 0;
		graphs_loaded = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no edges: every start comes straight back as a single last beat
		load_adjacency('0);
		for (int s = 0; s < VERTICES; s++) begin
			send_start(VTX_W'(s));
		end
		finish_phase(4);

		// complete graph with self loops
		load_adjacency('1);
		send_start('0);
		send_start(VTX_W'(VERTICES - 1));
		finish_phase(4);

		// self loops only must not push a vertex again
		g = '0;
		for (int i = 0; i < VERTICES; i++) begin
			g[i * 9] = 1'b1;
		end
		load_adjacency(g);
		send_start(VTX_W'(3));
		finish_phase(4);

		// forward chain with self loops: deepest walk
		for (int i = 0; i < VERTICES - 1; i++) begin
			g[i * 8 + i + 1] = 1'b1;
		end
		load_adjacency(g);
		send_start('0);
		send_start(VTX_W'(5));
		finish_phase(4);

		// star around vertex 0 with edges back: widest stack
		g = '0;
		for (int i = 0; i < VERTICES; i++) begin
			g[i]     = 1'b1;
			g[i * 8] = 1'b1;
		end
		load_adjacency(g);
		send_start('0);
		send_start(VTX_W'(4));
		finish_phase(4);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			steady = (p % 4 == 3);
			load_adjacency(make_graph(graph_kind_t'(p % 4)));
			repeat (PHASE_ITEMS) send_start(VTX_W'($urandom_range(0, VERTICES - 1)));
			finish_phase(4);
		end
		steady = 1'b0;
		repeat (WALK_CYCLES) @(posedge clk);

		errors = board.mismatches + cfg_errors + board.outstanding();
		$display("Run covered %0d walks and %0d visit beats over %0d adjacency settings,",
			board.walks, board.visits_checked, graphs_loaded);
		$display("from the empty and complete graphs through chains, stars, trees and random ones.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
